// ===== sv/tkst_pkg.sv =====
// Shared types, widths and helpers for the top-k score table.
// Used by tkst_cell, top_k_score_table and the bench tb; depends on nothing else.
package tkst_pkg;

    localparam int ENTRIES    = 16;
    localparam int NAME_CHARS = 8;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CMD_W      = 2;
    localparam int SCORE_W    = 31;
    localparam int NAME_W     = 64;
    localparam int POS_W      = 4;
    localparam int IN_FIELDS_W  = SCORE_W + NAME_W + POS_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = POS_W + SCORE_W + NAME_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_SUBMIT = 2'd0,
        CMD_RENAME = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [NAME_W-1:0]  name;
    } t_entry;

    // broadcast to every cell of the row
    typedef struct packed {
        logic               ins;
        logic [SCORE_W-1:0] score;
        logic [NAME_W-1:0]  name;
        logic [SCORE_W-1:0] low;
    } t_cell_cmd;

    typedef struct packed {
        logic               accepted;
        logic [POS_W-1:0]   position;
        logic [SCORE_W-1:0] entry_score;
        logic [NAME_W-1:0]  entry_name;
    } t_result;

    // keep the low NAME_CHARS bytes, clear everything from the first zero byte on
    function automatic logic [NAME_W-1:0] name_form(input logic [NAME_W-1:0] v);
        logic [NAME_W-1:0] r;
        logic              stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < NAME_CHARS; i++) begin
            if (v[8*i +: 8] == 8'd0) begin
                stop = 1'b1;
            end
            if (!stop) begin
                r[8*i +: 8] = v[8*i +: 8];
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/tkst_cell.sv =====
// One slot of the sorted score row: holds a (score, name) pair and takes
// either the new entry, its upper neighbour's entry, or keeps its own,
// and a rename replaces its name. Depends on tkst_pkg.
module tkst_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tkst_pkg::t_cell_cmd i_cmd,
    input  logic               i_ren,
    input  tkst_pkg::t_entry   i_prev,
    input  logic               i_prev_lt,
    input  logic               i_prev_eq,
    output tkst_pkg::t_entry   o_entry,
    output logic               o_lt,
    output logic               o_eq,
    output logic               o_hit
);
    import tkst_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    assign o_entry = r_entry;
    assign o_lt    = r_entry.score < i_cmd.score;
    assign o_eq    = r_entry.score == i_cmd.low;
    // an earlier equal pair wins the reported position
    assign o_hit   = !o_lt && (r_entry.score == i_cmd.score) && (r_entry.name == i_cmd.name);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins && o_lt) begin
            if (!i_prev_lt) begin
                n_entry.score = i_cmd.score;
                n_entry.name  = i_cmd.name;
            end else if (!i_prev_eq) begin
                // between insert point and evicted slot: shift down by one
                n_entry = i_prev;
            end
        end
        if (i_ren) begin
            n_entry.name = i_cmd.name;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

// ===== sv/top_k_score_table.sv =====
// Top level of the top-k score table: a row of tkst_cell slots plus the
// command decode, position encode and output register. Depends on tkst_pkg.
//
// Usage:
//   Input stream (s_*): one transaction per command. s_tuser carries the
//   command (submit, rename, read); s_tdata carries score, name and index.
//   Output stream (m_*): exactly one result transaction per command.
//   m_tuser is the accepted flag; m_tdata holds position, score and name.
//   A result is loaded into the output register in the cycle after its
//   command is taken. Throughput: one command per cycle unless m_tready stalls;
//   every slot compares against the incoming score in parallel and shifts
//   from its neighbour in the same cycle, so the row of cells sets the rate.
//   Stalls: the output register holds its result while m_tready is low; a
//   new command is taken only when that register is empty or being emptied,
//   so s_tready follows m_tready once a result is pending.
//   Reset (synchronous, active low) empties the table: every slot holds a
//   zero score and a zero name, and the output register is emptied.
//   Scores are kept descending; an equal score goes behind existing ones,
//   and the first slot holding the lowest score is the one evicted.
module top_k_score_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [30:0] score, [94:31] player_name, [98:95] index, rest zero
    input  logic [tkst_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // [1:0] cmd
    input  logic [tkst_pkg::CMD_W-1:0]        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [3:0] position, [34:4] entry_score, [98:35] entry_name, rest zero
    output logic [tkst_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // [0] accepted
    output logic                              o_m_tuser
);
    import tkst_pkg::*;

    t_cmd               w_cmd;
    logic [SCORE_W-1:0] w_score;
    logic [NAME_W-1:0]  w_name;
    logic [POS_W-1:0]   w_index;
    logic [IDX_W-1:0]   w_idx;
    logic               w_in_range;
    logic               w_fire;
    logic               w_sub_ok;
    t_cell_cmd          w_ccmd;

    t_entry             w_entry [ENTRIES];
    logic [ENTRIES-1:0] w_lt;
    logic [ENTRIES-1:0] w_eq;
    logic [ENTRIES-1:0] w_hit;
    logic [ENTRIES-1:0] w_ren;
    logic [ENTRIES-1:0] w_sel;
    logic [ENTRIES-1:0] w_first;
    logic [IDX_W-1:0]   w_pos_enc;
    logic               w_sorted;

    t_result r_out;
    t_result n_out;
    logic    r_valid;
    logic    n_valid;

    assign w_cmd      = t_cmd'(i_s_tuser);
    assign w_score    = i_s_tdata[SCORE_W-1:0];
    assign w_name     = name_form(i_s_tdata[SCORE_W +: NAME_W]);
    assign w_index    = i_s_tdata[SCORE_W+NAME_W +: POS_W];
    assign w_idx      = IDX_W'(w_index);
    assign w_in_range = 32'(w_index) < ENTRIES;
    assign o_s_tready = !r_valid || i_m_tready;
    assign w_fire     = i_s_tvalid && o_s_tready;
    // positive and above the last slot's score (an empty last slot holds zero)
    assign w_sub_ok   = w_lt[ENTRIES-1];

    assign w_ccmd.ins   = w_fire && (w_cmd == CMD_SUBMIT) && w_sub_ok;
    assign w_ccmd.score = w_score;
    assign w_ccmd.name  = w_name;
    assign w_ccmd.low   = w_entry[ENTRIES-1].score;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        assign w_ren[g] = w_fire && (w_cmd == CMD_RENAME) && w_in_range
                          && (w_idx == IDX_W'(g));
        if (g == 0) begin : g_head
            tkst_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (w_ccmd),
                .i_ren     (w_ren[g]),
                .i_prev    ('0),
                .i_prev_lt (1'b0),
                .i_prev_eq (1'b0),
                .o_entry   (w_entry[g]),
                .o_lt      (w_lt[g]),
                .o_eq      (w_eq[g]),
                .o_hit     (w_hit[g])
            );
            assign w_sel[g] = w_hit[g] || w_lt[g];
        end else begin : g_body
            tkst_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (w_ccmd),
                .i_ren     (w_ren[g]),
                .i_prev    (w_entry[g-1]),
                .i_prev_lt (w_lt[g-1]),
                .i_prev_eq (w_eq[g-1]),
                .o_entry   (w_entry[g]),
                .o_lt      (w_lt[g]),
                .o_eq      (w_eq[g]),
                .o_hit     (w_hit[g])
            );
            assign w_sel[g] = w_hit[g] || (w_lt[g] && !w_lt[g-1]);
        end
    end

    // matches sit above the insert point, so the lowest set bit is the answer
    assign w_first = w_sel & (~w_sel + 1'b1);

    always_comb begin
        w_pos_enc = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_first[i]) begin
                w_pos_enc = w_pos_enc | IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_out = '0;
        case (w_cmd)
            CMD_SUBMIT: begin
                if (w_sub_ok) begin
                    n_out.accepted    = 1'b1;
                    n_out.position    = POS_W'(w_pos_enc);
                    n_out.entry_score = w_score;
                    n_out.entry_name  = w_name;
                end
            end
            CMD_RENAME: begin
                n_out.position = w_index;
                if (w_in_range) begin
                    n_out.accepted    = 1'b1;
                    n_out.entry_score = w_entry[w_idx].score;
                    n_out.entry_name  = w_name;
                end
            end
            CMD_READ: begin
                n_out.position = w_index;
                if (w_in_range) begin
                    n_out.accepted    = 1'b1;
                    n_out.entry_score = w_entry[w_idx].score;
                    n_out.entry_name  = w_entry[w_idx].name;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (w_fire) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_out.accepted;
    assign o_m_tdata  = OUT_TDATA_W'({r_out.entry_name, r_out.entry_score, r_out.position});

    always_comb begin
        w_sorted = 1'b1;
        for (int i = 0; i < ENTRIES - 1; i++) begin
            if (w_entry[i].score < w_entry[i+1].score) begin
                w_sorted = 1'b0;
            end
        end
    end

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n) w_sorted)
        else $error("score row lost its descending order");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_out.accepted) |-> (r_out.entry_score == '0 && r_out.entry_name == '0))
        else $error("rejected result carries entry data");

    a_submit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_cmd == CMD_SUBMIT && w_sub_ok) |=> (r_out.entry_score != '0))
        else $error("accepted submit reported a zero score");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (w_entry[ENTRIES-1].score == '0 && !r_valid))
        else $error("table not emptied by reset");

endmodule

// ===== dv/tb.sv =====
// Self-checking bench for top_k_score_table: directed and random commands
// streamed in, results checked against a sorted-table predictor held here.
// Depends on tkst_pkg and top_k_score_table.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tkst_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 100000;
    localparam int DRAIN_CYCLES = 5;
    localparam int RANDOM_PER_PHASE = 412;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [SCORE_W-1:0] score;
        logic [NAME_W-1:0]  name;
        logic [POS_W-1:0]   idx;
    } t_table_cmd;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic [CMD_W-1:0]       i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;

    top_k_score_table u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [SCORE_W-1:0] rank_score [ENTRIES];
    logic [NAME_W-1:0]  rank_name  [ENTRIES];

    t_table_cmd cmd_queue[$];
    t_result    result_queue[$];
    int         n_errors = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       in_taken = 1'b0;

    // bytes from the first zero byte upwards are dropped
    function automatic logic [NAME_W-1:0] trim_name(logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] r;
        r = '0;
        for (int b = 0; b < NAME_CHARS; b++) begin
            if (raw[8*b +: 8] == 8'd0) begin
                break;
            end
            r[8*b +: 8] = raw[8*b +: 8];
        end
        return r;
    endfunction

    function automatic t_result rank_table_apply(t_table_cmd c);
        t_result            r;
        logic [NAME_W-1:0]  nm;
        logic [SCORE_W-1:0] low;
        int                 evict;
        int                 slot;
        r  = '0;
        nm = trim_name(c.name);
        case (c.cmd)
            CMD_SUBMIT: begin
                low = rank_score[ENTRIES-1];
                if (c.score != '0 && (low == '0 || c.score > low)) begin
                    evict = ENTRIES - 1;
                    for (int i = ENTRIES - 1; i >= 0; i--) begin
                        if (rank_score[i] == low) evict = i;
                    end
                    for (int i = evict; i < ENTRIES - 1; i++) begin
                        rank_score[i] = rank_score[i+1];
                        rank_name[i]  = rank_name[i+1];
                    end
                    // ties go behind existing entries
                    slot = ENTRIES - 1;
                    for (int i = ENTRIES - 2; i >= 0; i--) begin
                        if (rank_score[i] < c.score) slot = i;
                    end
                    for (int i = ENTRIES - 1; i > slot; i--) begin
                        rank_score[i] = rank_score[i-1];
                        rank_name[i]  = rank_name[i-1];
                    end
                    rank_score[slot] = c.score;
                    rank_name[slot]  = nm;
                    // report the first matching pair, which may be an older duplicate
                    for (int i = ENTRIES - 1; i >= 0; i--) begin
                        if (rank_score[i] == c.score && rank_name[i] == nm) begin
                            r.accepted    = 1'b1;
                            r.position    = POS_W'(i);
                            r.entry_score = rank_score[i];
                            r.entry_name  = rank_name[i];
                        end
                    end
                end
            end
            CMD_RENAME, CMD_READ: begin
                r.position = c.idx;
                if (int'(c.idx) < ENTRIES) begin
                    if (c.cmd == CMD_RENAME) rank_name[c.idx] = nm;
                    r.accepted    = 1'b1;
                    r.entry_score = rank_score[c.idx];
                    r.entry_name  = rank_name[c.idx];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(string fname, logic [NAME_W-1:0] exp_v,
                               logic [NAME_W-1:0] act_v);
        if (exp_v !== act_v) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, fname, exp_v, act_v);
        end
    endtask

    // input acceptance feeds the predictor, output acceptance is checked
    always @(posedge i_clk) begin
        t_table_cmd c;
        t_result    exp_r;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (result_queue.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, got %h/%h",
                             $time, o_m_tuser, o_m_tdata);
                end else begin
                    exp_r = result_queue.pop_front();
                    check_field("accepted", NAME_W'(exp_r.accepted), NAME_W'(o_m_tuser));
                    check_field("position", NAME_W'(exp_r.position),
                                NAME_W'(o_m_tdata[POS_W-1:0]));
                    check_field("entry_score", NAME_W'(exp_r.entry_score),
                                NAME_W'(o_m_tdata[POS_W +: SCORE_W]));
                    check_field("entry_name", exp_r.entry_name,
                                o_m_tdata[POS_W+SCORE_W +: NAME_W]);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                c.cmd   = i_s_tuser;
                c.score = i_s_tdata[SCORE_W-1:0];
                c.name  = i_s_tdata[SCORE_W +: NAME_W];
                c.idx   = i_s_tdata[SCORE_W+NAME_W +: POS_W];
                result_queue.push_back(rank_table_apply(c));
            end
            in_taken <= i_s_tvalid && o_s_tready;
        end
    end

    // driver and sink backpressure, changed on the falling edge
    always @(negedge i_clk) begin
        t_table_cmd c;
        logic       next_valid;
        if (i_rst_n) begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (!i_s_tvalid || in_taken) begin
                next_valid = 1'b0;
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    c = cmd_queue.pop_front();
                    next_valid = 1'b1;
                    i_s_tuser <= c.cmd;
                    i_s_tdata <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, c.idx, c.name, c.score};
                end
                i_s_tvalid <= next_valid;
            end
        end
    end

    function automatic logic [NAME_W-1:0] pick_name();
        logic [NAME_W-1:0] nm;
        int                roll;
        roll = $urandom_range(99);
        nm   = {$urandom, $urandom};
        if (roll < 40) begin
            // small pool so that identical score/name pairs recur
            case ($urandom_range(3))
                0: nm = 64'h0000_0000_0000_4241;
                1: nm = 64'h4847_4645_4443_4241;
                2: nm = 64'h0000_0000_0000_0000;
                default: nm = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
        end else if (roll < 60) begin
            nm[8*$urandom_range(NAME_CHARS-1) +: 8] = 8'd0;
        end
        return nm;
    endfunction

    // scores track a rising base so the table keeps turning over
    function automatic logic [SCORE_W-1:0] pick_score(int unsigned seq);
        longint base;
        int     roll;
        base = longint'(seq) * 1700000;
        if (base > 64'h7FFF_FF00) base = 64'h7FFF_FF00;
        roll = $urandom_range(99);
        if (roll < 5) return '0;
        if (roll < 6) return SCORE_W'(31'h7FFF_FFFF - $urandom_range(3));
        if (roll < 16) return SCORE_W'(base + $urandom_range(1 << 21));
        if (roll < 26 && base > 200) return SCORE_W'(base - $urandom_range(200));
        return SCORE_W'(base + $urandom_range(15));
    endfunction

    task automatic push_cmd(logic [CMD_W-1:0] cmd, logic [SCORE_W-1:0] score,
                            logic [NAME_W-1:0] name, logic [POS_W-1:0] idx);
        t_table_cmd c;
        c.cmd   = cmd;
        c.score = score;
        c.name  = name;
        c.idx   = idx;
        cmd_queue.push_back(c);
    endtask

    task automatic push_random(int count, ref int unsigned seq);
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 60) begin
                push_cmd(CMD_SUBMIT, pick_score(seq), pick_name(), POS_W'($urandom));
            end else if (roll < 75) begin
                push_cmd(CMD_RENAME, SCORE_W'($urandom), pick_name(), POS_W'($urandom));
            end else if (roll < 95) begin
                push_cmd(CMD_READ, SCORE_W'($urandom), pick_name(), POS_W'($urandom));
            end else begin
                push_cmd(CMD_UNUSED, SCORE_W'($urandom), pick_name(), POS_W'($urandom));
            end
            seq++;
        end
    endtask

    initial begin
        int unsigned seq;
        seq = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            rank_score[i] = '0;
            rank_name[i]  = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, ties, duplicates, renames, unused command
        push_cmd(CMD_READ,   '0, '0, 4'd0);
        push_cmd(CMD_READ,   '0, '0, 4'd15);
        push_cmd(CMD_SUBMIT, '0, 64'h0000_0000_0000_0041, 4'd0);
        push_cmd(CMD_SUBMIT, 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        push_cmd(CMD_SUBMIT, 31'd1, 64'h4142_0043_4445_4647, 4'd0);
        push_cmd(CMD_SUBMIT, 31'd1, 64'h0, 4'd0);
        push_cmd(CMD_SUBMIT, 31'd1, 64'h4142_0043_4445_4647, 4'd0);
        push_cmd(CMD_SUBMIT, 31'd5, 64'h0000_0000_0058_5958, 4'd0);
        push_cmd(CMD_RENAME, '0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        push_cmd(CMD_RENAME, '0, 64'h0, 4'd0);
        push_cmd(CMD_READ,   '0, '0, 4'd0);
        push_cmd(CMD_READ,   '0, '0, 4'd15);
        push_cmd(CMD_UNUSED, 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        push_cmd(CMD_SUBMIT, 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        push_cmd(CMD_RENAME, '0, 64'hFFFF_FFFF_FFFF_FF00, 4'd1);
        push_cmd(CMD_READ,   31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1);
        push_cmd(CMD_SUBMIT, 31'd5, 64'h0000_0000_0058_5958, 4'd0);

        send_idle_pct  = 34;
        recv_stall_pct = 45;
        push_random(RANDOM_PER_PHASE, seq);
        while (cmd_queue.size() != 0) @(posedge i_clk);

        send_idle_pct  = 45;
        recv_stall_pct = 34;
        push_random(RANDOM_PER_PHASE, seq);
        while (cmd_queue.size() != 0) @(posedge i_clk);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_random(RANDOM_PER_PHASE, seq);

        while (cmd_queue.size() != 0 || i_s_tvalid || result_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
